// File: design/eos_pkg.sv
// Package for the event occupancy sweep: sizes, types and state codes.
package eos_pkg;
	localparam int MaxEvents = 8192;
	localparam int AW = $clog2(MaxEvents);
	localparam int CW = $clog2(MaxEvents + 1);
	localparam logic [19:0] UsecPerSec = 20'd1000000;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_READ = 1'b1
	} op_t;

	typedef struct packed {
		logic signed [52:0] offset;
		logic               start;
	} event_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_WR_START,
		ST_WR_FINISH,
		ST_SORT_RD_A,
		ST_SORT_RD_B,
		ST_SORT_CMP,
		ST_SORT_TAIL,
		ST_COPY_RD,
		ST_COPY_WR,
		ST_READ_RD,
		ST_READ_WAIT,
		ST_OUT
	} state_t;
endpackage

// File: design/event_occupancy_sweep.sv
// Top level of the event occupancy sweep: store, merge sorter and sweep reader.
//
// Input channel (in_valid/in_stall) takes one beat per operation. A load beat
// carries a record with start and finish times; the first accepted record's
// start is time zero and both events are written to the event memory. A read
// beat returns one beat on the output channel (out_valid/out_stall) with the
// next event in time order, the running queue depth and a last mark, or
// nothing_left when all events are consumed. Loads give no output beat.
// A load steps through a multiply and two memory writes (start, then finish)
// before the next accept. A read steps through a store read, a wait and the
// output register before raising out_valid; input stays stalled while
// out_valid is high. The first read first runs a bottom-up stable merge sort:
// each pass reads, compares and writes every event to the buffer, with one
// extra step per merged block after the first, then copies the buffer back,
// for ceil(log2 n) passes; loads after that are ignored.
// Reset clears all control state; memory contents are undefined but only
// written entries are ever read. While out_stall is high the result is
// held in the output register and no new beat is accepted.
module event_occupancy_sweep (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 operation,
	input  logic [31:0]          start_seconds,
	input  logic [19:0]          start_microseconds,
	input  logic [31:0]          finish_seconds,
	input  logic [19:0]          finish_microseconds,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [52:0]   time_offset_us,
	output logic signed [14:0]   queue_depth,
	output logic                 is_start,
	output logic                 last_event,
	output logic                 nothing_left,
	output logic                 records_dropped
);
	localparam int AW = eos_pkg::AW;
	localparam int CW = eos_pkg::CW;

	eos_pkg::state_t state_q, state_d;

	eos_pkg::event_t store_mem [eos_pkg::MaxEvents];
	eos_pkg::event_t buf_mem   [eos_pkg::MaxEvents];
	eos_pkg::event_t store_rd_q, buf_rd_q;
	logic            st_we, bf_we;
	logic [AW-1:0]   st_addr, bf_addr;
	eos_pkg::event_t st_wd, bf_wd;

	logic [51:0] s_q, f_q, origin_q;
	logic        origin_taken_q, sorted_q, overflow_q;
	logic [CW-1:0] count_q, rpos_q;
	logic signed [14:0] depth_q;

	logic [31:0] ss_q, fs_q;
	logic [19:0] su_q, fu_q;

	// merge pass bookkeeping
	logic [CW:0] width_q, lo_q, a_q, b_q, mid_q, hi_q, k_q;
	eos_pkg::event_t ea_q;

	logic accept;
	assign in_stall = (state_q != eos_pkg::ST_IDLE) || out_valid;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk) begin
		if (st_we) store_mem[st_addr] <= st_wd;
		store_rd_q <= store_mem[st_addr];
	end
	always_ff @(posedge clk) begin
		if (bf_we) buf_mem[bf_addr] <= bf_wd;
		buf_rd_q <= buf_mem[bf_addr];
	end

	logic [CW:0] cnt_x;
	assign cnt_x = {1'b0, count_q};

	logic [CW:0] mid_n, hi_n;
	always_comb begin
		mid_n = (lo_q + width_q < cnt_x) ? lo_q + width_q : cnt_x;
		hi_n  = (lo_q + (width_q << 1) < cnt_x) ? lo_q + (width_q << 1) : cnt_x;
	end

	// b entry lands in store_rd_q during ST_SORT_CMP
	logic take_b;
	assign take_b = (a_q >= mid_q) || ((b_q < hi_q) && (store_rd_q.offset < ea_q.offset));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			eos_pkg::ST_IDLE: begin
				if (accept) begin
					if (operation == eos_pkg::OP_READ)
						state_d = sorted_q ? eos_pkg::ST_READ_RD :
							(count_q > CW'(1) ? eos_pkg::ST_SORT_RD_A : eos_pkg::ST_READ_RD);
					else if (!sorted_q && (cnt_x + (CW+1)'(2) <= (CW+1)'(eos_pkg::MaxEvents)))
						state_d = eos_pkg::ST_MUL;
				end
			end
			eos_pkg::ST_MUL:       state_d = eos_pkg::ST_WR_START;
			eos_pkg::ST_WR_START:  state_d = eos_pkg::ST_WR_FINISH;
			eos_pkg::ST_WR_FINISH: state_d = eos_pkg::ST_IDLE;
			eos_pkg::ST_SORT_RD_A: state_d = eos_pkg::ST_SORT_RD_B;
			eos_pkg::ST_SORT_RD_B: state_d = eos_pkg::ST_SORT_CMP;
			eos_pkg::ST_SORT_CMP: begin
				if (k_q + (CW+1)'(1) >= hi_q)
					state_d = (hi_q >= cnt_x) ? eos_pkg::ST_COPY_RD : eos_pkg::ST_SORT_TAIL;
				else
					state_d = eos_pkg::ST_SORT_RD_A;
			end
			eos_pkg::ST_SORT_TAIL: state_d = eos_pkg::ST_SORT_RD_A;
			eos_pkg::ST_COPY_RD:   state_d = eos_pkg::ST_COPY_WR;
			eos_pkg::ST_COPY_WR: begin
				if (k_q + (CW+1)'(1) < cnt_x) state_d = eos_pkg::ST_COPY_RD;
				else if ((width_q << 1) < cnt_x) state_d = eos_pkg::ST_SORT_RD_A;
				else state_d = eos_pkg::ST_READ_RD;
			end
			eos_pkg::ST_READ_RD:   state_d = eos_pkg::ST_READ_WAIT;
			eos_pkg::ST_READ_WAIT: state_d = eos_pkg::ST_OUT;
			eos_pkg::ST_OUT:       state_d = eos_pkg::ST_IDLE;
			default:               state_d = eos_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		st_we   = 1'b0;
		bf_we   = 1'b0;
		st_addr = rpos_q[AW-1:0];
		bf_addr = k_q[AW-1:0];
		st_wd   = '0;
		bf_wd   = take_b ? store_rd_q : ea_q;
		unique case (state_q)
			eos_pkg::ST_WR_START: begin
				st_we   = 1'b1;
				st_addr = count_q[AW-1:0];
				st_wd.offset = origin_taken_q ?
					53'(signed'({1'b0, s_q})) - 53'(signed'({1'b0, origin_q})) : '0;
				st_wd.start  = 1'b1;
			end
			eos_pkg::ST_WR_FINISH: begin
				st_we   = 1'b1;
				st_addr = count_q[AW-1:0];
				st_wd.offset = 53'(signed'({1'b0, f_q})) - 53'(signed'({1'b0, origin_q}));
				st_wd.start  = 1'b0;
			end
			eos_pkg::ST_SORT_RD_A: st_addr = a_q[AW-1:0];
			eos_pkg::ST_SORT_RD_B: st_addr = b_q[AW-1:0];
			eos_pkg::ST_SORT_CMP:  bf_we = 1'b1;
			eos_pkg::ST_COPY_WR: begin
				st_we   = 1'b1;
				st_addr = k_q[AW-1:0];
				st_wd   = buf_rd_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= eos_pkg::ST_IDLE;
			origin_q        <= '0;
			origin_taken_q  <= 1'b0;
			sorted_q        <= 1'b0;
			overflow_q      <= 1'b0;
			count_q         <= '0;
			rpos_q          <= '0;
			depth_q         <= '0;
			out_valid       <= 1'b0;
			width_q         <= '0;
			lo_q            <= '0;
			a_q             <= '0;
			b_q             <= '0;
			mid_q           <= '0;
			hi_q            <= '0;
			k_q             <= '0;
			ea_q            <= '0;
			time_offset_us  <= '0;
			queue_depth     <= '0;
			is_start        <= 1'b0;
			last_event      <= 1'b0;
			nothing_left    <= 1'b0;
			records_dropped <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (state_q)
				eos_pkg::ST_IDLE: begin
					if (accept && operation == eos_pkg::OP_LOAD && !sorted_q &&
						!(cnt_x + (CW+1)'(2) <= (CW+1)'(eos_pkg::MaxEvents)))
						overflow_q <= 1'b1;
					if (accept && operation == eos_pkg::OP_READ && !sorted_q) begin
						sorted_q <= 1'b1;
						width_q  <= (CW+1)'(1);
						lo_q     <= '0;
						a_q      <= '0;
						k_q      <= '0;
						b_q      <= (CW+1)'(1) < cnt_x ? (CW+1)'(1) : cnt_x;
						mid_q    <= (CW+1)'(1) < cnt_x ? (CW+1)'(1) : cnt_x;
						hi_q     <= (CW+1)'(2) < cnt_x ? (CW+1)'(2) : cnt_x;
					end
				end
				eos_pkg::ST_WR_START: begin
					count_q <= count_q + CW'(1);
					if (!origin_taken_q) begin
						origin_q       <= s_q;
						origin_taken_q <= 1'b1;
					end
				end
				eos_pkg::ST_WR_FINISH: count_q <= count_q + CW'(1);
				eos_pkg::ST_SORT_RD_B: ea_q <= store_rd_q;
				eos_pkg::ST_SORT_CMP: begin
					if (take_b) b_q <= b_q + (CW+1)'(1);
					else a_q <= a_q + (CW+1)'(1);
					if (k_q + (CW+1)'(1) >= hi_q) begin
						if (hi_q >= cnt_x) k_q <= '0;
						else lo_q <= hi_q;
					end else
						k_q <= k_q + (CW+1)'(1);
				end
				eos_pkg::ST_SORT_TAIL: begin
					a_q   <= lo_q;
					b_q   <= mid_n;
					mid_q <= mid_n;
					hi_q  <= hi_n;
					k_q   <= lo_q;
				end
				eos_pkg::ST_COPY_WR: begin
					if (k_q + (CW+1)'(1) < cnt_x)
						k_q <= k_q + (CW+1)'(1);
					else if ((width_q << 1) < cnt_x) begin
						width_q <= width_q << 1;
						lo_q    <= '0;
						a_q     <= '0;
						k_q     <= '0;
						b_q     <= ((width_q << 1) < cnt_x) ? (width_q << 1) : cnt_x;
						mid_q   <= ((width_q << 1) < cnt_x) ? (width_q << 1) : cnt_x;
						hi_q    <= ((width_q << 2) < cnt_x) ? (width_q << 2) : cnt_x;
					end
				end
				eos_pkg::ST_OUT: begin
					out_valid       <= 1'b1;
					records_dropped <= overflow_q;
					if (rpos_q >= count_q) begin
						time_offset_us <= '0;
						queue_depth    <= '0;
						is_start       <= 1'b0;
						last_event     <= 1'b0;
						nothing_left   <= 1'b1;
					end else begin
						time_offset_us <= store_rd_q.offset;
						queue_depth    <= store_rd_q.start ? depth_q + 15'sd1 : depth_q - 15'sd1;
						depth_q        <= store_rd_q.start ? depth_q + 15'sd1 : depth_q - 15'sd1;
						is_start       <= store_rd_q.start;
						last_event     <= (rpos_q + CW'(1) == count_q);
						nothing_left   <= 1'b0;
						rpos_q         <= rpos_q + CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ss_q <= start_seconds;
			su_q <= start_microseconds;
			fs_q <= finish_seconds;
			fu_q <= finish_microseconds;
		end
		if (state_q == eos_pkg::ST_MUL) begin
			s_q <= 52'(ss_q) * 52'(eos_pkg::UsecPerSec) + 52'(su_q);
			f_q <= 52'(fs_q) * 52'(eos_pkg::UsecPerSec) + 52'(fu_q);
		end
	end
endmodule

// File: bench/sweep_checker.sv
// Checker for the event occupancy sweep: watches both channels, predicts each result beat, compares.
module sweep_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic                operation,
	input  logic [31:0]         start_seconds,
	input  logic [19:0]         start_microseconds,
	input  logic [31:0]         finish_seconds,
	input  logic [19:0]         finish_microseconds,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic signed [52:0]  time_offset_us,
	input  logic signed [14:0]  queue_depth,
	input  logic                is_start,
	input  logic                last_event,
	input  logic                nothing_left,
	input  logic                records_dropped,
	output int                  errors,
	output int                  outstanding,
	output int                  results_seen,
	output int                  empty_reads,
	output int                  events_held
);
	typedef struct {
		logic signed [52:0] offset;
		logic signed [14:0] depth;
		logic               start;
		logic               last;
		logic               empty;
		logic               dropped;
	} sweep_beat_t;

	sweep_beat_t        expected_beats[$];
	logic signed [52:0] ev_offset[eos_pkg::MaxEvents];
	logic               ev_start[eos_pkg::MaxEvents];
	int                 sorted_index[$];
	logic [51:0]        origin_us;
	logic               origin_set;
	logic               store_sorted;
	logic               overflow_seen;
	int                 read_pos;
	logic signed [14:0] run_depth;

	initial begin
		errors = 0;
		outstanding = 0;
		results_seen = 0;
		empty_reads = 0;
		events_held = 0;
		origin_us = '0;
		origin_set = 1'b0;
		store_sorted = 1'b0;
		overflow_seen = 1'b0;
		read_pos = 0;
		run_depth = '0;
	end

	function automatic logic [51:0] to_usec(logic [31:0] sec, logic [19:0] usec);
		return 52'(sec) * 52'd1000000 + 52'(usec);
	endfunction

	task automatic report_mismatch(string field, longint got, longint want);
		$display("mismatch on result %0d: %s got %0d expected %0d", results_seen, field, got, want);
		errors++;
	endtask

	task automatic record_load();
		logic [51:0] s_us;
		logic [51:0] f_us;
		if (store_sorted)
			return;
		if (events_held + 2 > eos_pkg::MaxEvents) begin
			overflow_seen = 1'b1;
			return;
		end
		s_us = to_usec(start_seconds, start_microseconds);
		f_us = to_usec(finish_seconds, finish_microseconds);
		if (!origin_set) begin
			origin_us = s_us;
			origin_set = 1'b1;
		end
		ev_offset[events_held] = $signed({1'b0, s_us}) - $signed({1'b0, origin_us});
		ev_start[events_held] = 1'b1;
		ev_offset[events_held + 1] = $signed({1'b0, f_us}) - $signed({1'b0, origin_us});
		ev_start[events_held + 1] = 1'b0;
		events_held += 2;
	endtask

	// Key is offset with the sign flipped, then load index, so ties keep load order.
	task automatic sort_store();
		logic [66:0] keys[$];
		for (int i = 0; i < events_held; i++)
			keys.push_back({~ev_offset[i][52], ev_offset[i][51:0], 14'(i)});
		keys.sort();
		sorted_index.delete();
		foreach (keys[k])
			sorted_index.push_back(int'(keys[k][13:0]));
		store_sorted = 1'b1;
	endtask

	task automatic sweep_next();
		sweep_beat_t b;
		int idx;
		if (!store_sorted)
			sort_store();
		b.dropped = overflow_seen;
		if (read_pos >= events_held) begin
			b.offset = '0;
			b.depth = '0;
			b.start = 1'b0;
			b.last = 1'b0;
			b.empty = 1'b1;
		end else begin
			idx = sorted_index[read_pos];
			run_depth = ev_start[idx] ? run_depth + 15'sd1 : run_depth - 15'sd1;
			b.offset = ev_offset[idx];
			b.depth = run_depth;
			b.start = ev_start[idx];
			b.last = (read_pos + 1 == events_held);
			b.empty = 1'b0;
			read_pos++;
		end
		expected_beats.push_back(b);
	endtask

	always @(posedge clk) begin
		sweep_beat_t w;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				if (eos_pkg::op_t'(operation) == eos_pkg::OP_LOAD)
					record_load();
				else
					sweep_next();
			end
			if (out_valid && !out_stall) begin
				if (expected_beats.size() == 0) begin
					report_mismatch("unexpected result beat", 1, 0);
				end else begin
					w = expected_beats.pop_front();
					if (time_offset_us !== w.offset)
						report_mismatch("time_offset_us", time_offset_us, w.offset);
					if (queue_depth !== w.depth)
						report_mismatch("queue_depth", queue_depth, w.depth);
					if (is_start !== w.start)
						report_mismatch("is_start", is_start, w.start);
					if (last_event !== w.last)
						report_mismatch("last_event", last_event, w.last);
					if (nothing_left !== w.empty)
						report_mismatch("nothing_left", nothing_left, w.empty);
					if (records_dropped !== w.dropped)
						report_mismatch("records_dropped", records_dropped, w.dropped);
				end
				if (nothing_left === 1'b1)
					empty_reads++;
				results_seen++;
			end
		end
		outstanding = expected_beats.size();
	end
endmodule

// File: bench/tb_top.sv
// Testbench top for the event occupancy sweep: reset, clock, stimulus, stalls and verdict.
module tb_top;
	localparam int StallLimit = 400000;
	localparam int LoadRecords = 580;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               operation = 1'b0;
	logic [31:0]        start_seconds = '0;
	logic [19:0]        start_microseconds = '0;
	logic [31:0]        finish_seconds = '0;
	logic [19:0]        finish_microseconds = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [52:0] time_offset_us;
	logic signed [14:0] queue_depth;
	logic               is_start;
	logic               last_event;
	logic               nothing_left;
	logic               records_dropped;

	int errors;
	int outstanding;
	int results_seen;
	int empty_reads;
	int events_held;
	int send_idle = 9;
	int recv_idle = 87;
	int items_sent = 0;
	int quiet_cycles = 0;

	event_occupancy_sweep u_top (.*);

	sweep_checker u_chk (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_idle);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= StallLimit) begin
			$display("watchdog: no beat for %0d cycles", quiet_cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic send_beat(eos_pkg::op_t op, logic [31:0] ss, logic [19:0] su,
			logic [31:0] fs, logic [19:0] fu);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		operation <= op;
		start_seconds <= ss;
		start_microseconds <= su;
		finish_seconds <= fs;
		finish_microseconds <= fu;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		items_sent++;
		if (items_sent == 580) begin
			send_idle = 87;
			recv_idle = 9;
		end else if (items_sent == 1160) begin
			send_idle = 0;
			recv_idle = 0;
		end
	endtask

	task automatic load_record(logic [31:0] ss, logic [19:0] su, logic [31:0] fs,
			logic [19:0] fu);
		send_beat(eos_pkg::OP_LOAD, ss, su, fs, fu);
	endtask

	task automatic read_event();
		send_beat(eos_pkg::OP_READ, $urandom, 20'($urandom), $urandom, 20'($urandom));
	endtask

	initial begin
		logic [31:0] ss;
		logic [19:0] su;
		logic [31:0] fs;
		logic [19:0] fu;
		int pick;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: origin, extremes, oversize microseconds, ties, zero length
		load_record(32'd100, 20'd0, 32'd100, 20'd999999);
		load_record(32'd0, 20'd0, 32'hFFFFFFFF, 20'd999999);
		load_record(32'hFFFFFFFF, 20'hFFFFF, 32'd0, 20'hFFFFF);
		load_record(32'd100, 20'd0, 32'd100, 20'd999999);
		load_record(32'd100, 20'd0, 32'd100, 20'd0);
		ss = 32'd120;
		su = 20'd5;
		fs = 32'd121;
		fu = 20'd7;
		for (int i = 5; i < LoadRecords; i++) begin
			pick = $urandom_range(99);
			if (pick < 78) begin
				ss = 32'd100 + $urandom_range(0, 40);
				su = 20'($urandom_range(0, 999999));
				fs = ss + $urandom_range(0, 3);
				fu = 20'($urandom_range(0, 999999));
			end else if (pick < 90) begin
				ss = fs;
				su = fu;
			end else begin
				ss = $urandom;
				su = 20'($urandom);
				fs = $urandom;
				fu = 20'($urandom);
			end
			load_record(ss, su, fs, fu);
		end
		read_event();
		// loads after reading began are ignored
		load_record(32'd0, 20'd0, 32'd0, 20'd0);
		load_record(32'hFFFFFFFF, 20'hFFFFF, 32'hFFFFFFFF, 20'hFFFFF);
		for (int i = 1; i < 2 * LoadRecords + 4; i++)
			read_event();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (40) @(posedge clk);
		$display("Loaded %0d events with ties and oversize microseconds, swept %0d result beats,",
			events_held, results_seen);
		$display("%0d reads after the sweep ran dry; three stall settings used.", empty_reads);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
